FILE: sv/lmts_pkg.sv
// Package for the LCD mode timing and status block.
// Holds the request and response payload types, mode codes, bus addresses and
// mode durations. No dependencies.
package lmts_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register addresses on the bus.
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;

  // Palette window 0xFF68..0xFF6B, compared without the two low bits.
  localparam logic [13:0] ADDR_PAL_BASE = 14'(16'hFF68 >> 2);
  // Tile window 0x8000..0x9FFF, compared on the three high bits.
  localparam logic [2:0]  ADDR_TILE_TOP = 3'b100;

  // Bit positions of the STAT interrupt enables.
  localparam int ENA_HBLANK = 0;
  localparam int ENA_VBLANK = 1;
  localparam int ENA_OAM    = 2;
  localparam int ENA_COINC  = 3;

  // Bit of LCDC that switches the display on.
  localparam int LCDC_DISPLAY_BIT = 7;

  // Controller modes.
  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } lcd_mode_t;

  // Mode durations in clock cycles.
  localparam logic [8:0] LEN_HBLANK   = 9'd204;
  localparam logic [8:0] LEN_VBLANK   = 9'd456;
  localparam logic [8:0] LEN_OAM      = 9'd80;
  localparam logic [8:0] LEN_TRANSFER = 9'd172;

  // Request payload: one tick or one bus access.
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  tick_cycles;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } lmts_req_t;

  // Response payload: one per request.
  typedef struct packed {
    logic [7:0] read_data;
    logic       access_ok;
    logic       vblank_request;
    logic       stat_request;
  } lmts_rsp_t;

  // Result of one mode transition.
  typedef struct packed {
    lcd_mode_t  mode;
    logic [7:0] line;
    logic       vb;
    logic       st;
  } lmts_step_t;

  // Duration of a mode.
  function automatic logic [8:0] mode_len(lcd_mode_t mode);
    logic [8:0] len;
    unique case (mode)
      MODE_HBLANK:   len = LEN_HBLANK;
      MODE_VBLANK:   len = LEN_VBLANK;
      MODE_OAM:      len = LEN_OAM;
      MODE_TRANSFER: len = LEN_TRANSFER;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/lmts_stream_if.sv
// Valid/ready channel interfaces for the LCD mode timing and status block.
// Depends on lmts_pkg for the payload types.
interface lmts_req_if import lmts_pkg::*; ();
  logic      valid;
  logic      ready;
  lmts_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lmts_rsp_if import lmts_pkg::*; ();
  logic      valid;
  logic      ready;
  lmts_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/lcd_mode_timing_stat_top.sv
// Top level of the LCD mode timing and status block.
// Depends on lmts_pkg and on the channel interfaces in lmts_stream_if.sv.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   req     | in        | op, tick_cycles, bus_address, write_data
//   rsp     | out       | read_data, access_ok, vblank_request, stat_request
//
// Every request is finished in the cycle it is accepted: the timer state is
// updated and the response is loaded into the output register, so one request
// per cycle is sustained while rsp is ready. A tick (tick_cycles up to 127) is
// resolved in closed form by two chained transition stages, since no more than
// two mode changes fit. Reset (rst, synchronous) clears the timer, the enables
// and the display bit. While a response waits in the output register, the next
// request is taken only if the response leaves in the same cycle.
module lcd_mode_timing_stat_top
  import lmts_pkg::*;
#(
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  logic          clk,
  input  logic          rst,
  lmts_req_if.sink      req,
  lmts_rsp_if.source    rsp
);

  localparam logic [7:0] VIS_LINE  = 8'(VISIBLE_LINES);
  localparam logic [8:0] LAST_LINE9 = 9'(LAST_LINE);

  // Timer and register state.
  lcd_mode_t  lcd_mode, lcd_mode_next;
  logic [8:0] mode_cycles, mode_cycles_next;
  logic [7:0] current_line, current_line_next;
  logic [7:0] compare_line, compare_line_next;
  logic [3:0] stat_enables, stat_enables_next;
  logic       display_on, display_on_next;

  // Output register.
  logic       rsp_valid;
  lmts_rsp_t  rsp_data;
  lmts_rsp_t  rsp_next;

  logic       req_fire;

  // One mode change at the end of the current mode.
  function automatic lmts_step_t line_step(lcd_mode_t mode, logic [7:0] line,
                                           logic [3:0] ena, logic [7:0] lyc);
    lmts_step_t s;
    logic [7:0] inc;
    logic [8:0] nxt;
    s.mode = mode;
    s.line = line;
    s.vb   = 1'b0;
    s.st   = 1'b0;
    inc    = line + 8'd1;
    nxt    = {1'b0, line} + 9'd1;
    unique case (mode)
      MODE_HBLANK: begin
        s.line = inc;
        s.st   = ena[ENA_COINC] && (inc == lyc);
        if (inc == VIS_LINE) begin
          s.mode = MODE_VBLANK;
          s.vb   = 1'b1;
          s.st   = s.st || ena[ENA_VBLANK];
        end else begin
          s.mode = MODE_OAM;
        end
      end
      MODE_VBLANK: begin
        if (nxt > LAST_LINE9) begin
          s.line = 8'd0;
          s.mode = MODE_OAM;
          s.st   = ena[ENA_OAM];
        end else begin
          s.line = nxt[7:0];
        end
      end
      MODE_OAM: begin
        s.mode = MODE_TRANSFER;
      end
      MODE_TRANSFER: begin
        s.mode = MODE_HBLANK;
        s.st   = ena[ENA_HBLANK];
      end
    endcase
    return s;
  endfunction

  // Tick resolution: a first change once the tick covers d1, a second once the rest covers len2.
  logic [8:0]  len1, len2;
  logic [9:0]  d1;
  logic        fire1, fire2;
  logic [6:0]  remain;
  lmts_step_t  step1, step2;

  always_comb begin
    len1   = mode_len(lcd_mode);
    d1     = (mode_cycles >= len1) ? 10'd1
                                   : ({1'b0, len1} - {1'b0, mode_cycles} + 10'd1);
    fire1  = {3'b000, req.payload.tick_cycles} >= d1;
    remain = 7'({3'b000, req.payload.tick_cycles} - d1);
    step1  = line_step(lcd_mode, current_line, stat_enables, compare_line);
    len2   = mode_len(step1.mode);
    fire2  = fire1 && ({2'b00, remain} >= len2);
    step2  = line_step(step1.mode, step1.line, stat_enables, compare_line);
  end

  // Next state and response for the request at the input.
  logic [15:0] addr;
  logic        in_tile, in_pal;

  always_comb begin
    lcd_mode_next     = lcd_mode;
    mode_cycles_next  = mode_cycles;
    current_line_next = current_line;
    compare_line_next = compare_line;
    stat_enables_next = stat_enables;
    display_on_next   = display_on;
    rsp_next          = '0;
    addr              = req.payload.bus_address;
    in_tile           = addr[15:13] == ADDR_TILE_TOP;
    in_pal            = addr[15:2] == ADDR_PAL_BASE;

    unique case (req.payload.op)
      OP_TICK: begin
        rsp_next.access_ok = 1'b1;
        if (display_on) begin
          if (fire2) begin
            lcd_mode_next     = step2.mode;
            current_line_next = step2.line;
            mode_cycles_next  = 9'({2'b00, remain} + 9'd1 - len2);
            rsp_next.vblank_request = step1.vb || step2.vb;
            rsp_next.stat_request   = step1.st || step2.st;
          end else if (fire1) begin
            lcd_mode_next     = step1.mode;
            current_line_next = step1.line;
            mode_cycles_next  = {2'b00, remain} + 9'd1;
            rsp_next.vblank_request = step1.vb;
            rsp_next.stat_request   = step1.st;
          end else begin
            mode_cycles_next = mode_cycles + {2'b00, req.payload.tick_cycles};
          end
        end
      end
      OP_READ: begin
        rsp_next.access_ok = 1'b1;
        if (addr == ADDR_STAT) begin
          rsp_next.read_data = {1'b0, stat_enables, current_line == compare_line,
                                lcd_mode};
        end else if (addr == ADDR_LYC) begin
          rsp_next.read_data = compare_line;
        end else if (addr == ADDR_LY) begin
          rsp_next.read_data = current_line;
        end else begin
          rsp_next.access_ok = 1'b0;
        end
      end
      OP_WRITE: begin
        rsp_next.access_ok = 1'b1;
        if (in_tile || in_pal) begin
          // Tile and palette data are accepted and dropped.
        end else if (addr == ADDR_LCDC) begin
          display_on_next = req.payload.write_data[LCDC_DISPLAY_BIT];
          if (!req.payload.write_data[LCDC_DISPLAY_BIT]) begin
            current_line_next = 8'd0;
            lcd_mode_next     = MODE_HBLANK;
          end
        end else if (addr == ADDR_STAT) begin
          stat_enables_next = req.payload.write_data[6:3];
        end else if (addr == ADDR_LYC) begin
          compare_line_next = req.payload.write_data;
        end else if (addr == ADDR_LY) begin
          current_line_next = 8'd0;
        end else begin
          rsp_next.access_ok = 1'b0;
        end
      end
      default: begin
        // Unknown operation: no effect, all response fields zero.
      end
    endcase
  end

  // Handshake: take a request whenever the output register is free or drains.
  assign req.ready   = !rsp_valid || rsp.ready;
  assign req_fire    = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_mode     <= MODE_HBLANK;
      mode_cycles  <= 9'd0;
      current_line <= 8'd0;
      compare_line <= 8'd0;
      stat_enables <= 4'd0;
      display_on   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (req_fire) begin
        lcd_mode     <= lcd_mode_next;
        mode_cycles  <= mode_cycles_next;
        current_line <= current_line_next;
        compare_line <= compare_line_next;
        stat_enables <= stat_enables_next;
        display_on   <= display_on_next;
        rsp_valid    <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid    <= 1'b0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

FILE: sim/tb_lcd_mode_timing_stat_top.sv
// Testbench for lcd_mode_timing_stat_top: drives ticks and bus accesses and checks every
// response against a cycle-by-cycle model of the LCD timer, with random stalls on both sides.
// Depends on lmts_pkg, lmts_stream_if.sv and the top level of the block.
`timescale 1ns / 1ps

module tb_lcd_mode_timing_stat_top;
  import lmts_pkg::*;

  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;
  // The op code that the block does not decode.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Enough full-length ticks to run through one whole frame, vblank included.
  localparam int unsigned FRAME_TICKS  = 560;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // Tracks the LCD timer and holds the responses still due from the block.
  class lcd_timing_board;
    lcd_mode_t   mode;
    logic [8:0]  mode_cyc;
    logic [7:0]  line;
    logic [7:0]  lyc;
    logic [3:0]  ena;
    logic        disp;
    lmts_rsp_t   due_rsp[$];
    int unsigned errors;

    function new();
      mode     = MODE_HBLANK;
      mode_cyc = '0;
      line     = '0;
      lyc      = '0;
      ena      = '0;
      disp     = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return due_rsp.size();
    endfunction

    function logic [8:0] mode_span(lcd_mode_t m);
      case (m)
        MODE_HBLANK: return LEN_HBLANK;
        MODE_VBLANK: return LEN_VBLANK;
        MODE_OAM:    return LEN_OAM;
        default:     return LEN_TRANSFER;
      endcase
    endfunction

    // One clock cycle of the timer; interrupt requests accumulate in vb and st.
    function void advance_cycle(inout logic vb, inout logic st);
      int unsigned next_line;
      if (mode_cyc >= mode_span(mode)) begin
        mode_cyc = '0;
        case (mode)
          MODE_HBLANK: begin
            line = line + 8'd1;
            if (ena[ENA_COINC] && line == lyc) st = 1'b1;
            if (line == 8'(VISIBLE_LINES)) begin
              mode = MODE_VBLANK;
              vb   = 1'b1;
              if (ena[ENA_VBLANK]) st = 1'b1;
            end else begin
              mode = MODE_OAM;
            end
          end
          MODE_VBLANK: begin
            next_line = 32'(line) + 1;
            if (next_line > LAST_LINE) begin
              line = '0;
              mode = MODE_OAM;
              if (ena[ENA_OAM]) st = 1'b1;
            end else begin
              line = 8'(next_line);
            end
          end
          MODE_OAM: mode = MODE_TRANSFER;
          default: begin
            mode = MODE_HBLANK;
            if (ena[ENA_HBLANK]) st = 1'b1;
          end
        endcase
      end
      mode_cyc = mode_cyc + 9'd1;
    endfunction

    // Applies an accepted request and queues the response it must produce.
    function void note_request(lmts_req_t r);
      lmts_rsp_t   o;
      logic        vb;
      logic        st;
      int unsigned n;
      o  = '0;
      vb = 1'b0;
      st = 1'b0;
      case (r.op)
        OP_TICK: begin
          o.access_ok = 1'b1;
          if (disp) begin
            for (n = 0; n < r.tick_cycles; n++) advance_cycle(vb, st);
          end
        end
        OP_READ: begin
          o.access_ok = 1'b1;
          if (r.bus_address == ADDR_STAT) o.read_data = {1'b0, ena, line == lyc, mode};
          else if (r.bus_address == ADDR_LYC) o.read_data = lyc;
          else if (r.bus_address == ADDR_LY) o.read_data = line;
          else o.access_ok = 1'b0;
        end
        OP_WRITE: begin
          o.access_ok = 1'b1;
          if (r.bus_address[15:13] == ADDR_TILE_TOP) begin
            // Tile data is accepted and dropped.
          end else if (r.bus_address[15:2] == ADDR_PAL_BASE) begin
            // Palette data is accepted and dropped.
          end else if (r.bus_address == ADDR_LCDC) begin
            disp = r.write_data[LCDC_DISPLAY_BIT];
            if (!disp) begin
              line = '0;
              mode = MODE_HBLANK;
            end
          end else if (r.bus_address == ADDR_STAT) begin
            ena = r.write_data[6:3];
          end else if (r.bus_address == ADDR_LYC) begin
            lyc = r.write_data;
          end else if (r.bus_address == ADDR_LY) begin
            line = '0;
          end else begin
            o.access_ok = 1'b0;
          end
        end
        default: ;
      endcase
      o.vblank_request = vb;
      o.stat_request   = st;
      due_rsp.push_back(o);
    endfunction

    function void field_mismatch(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares a response from the block with the oldest one due.
    function void check_response(lmts_rsp_t a);
      lmts_rsp_t e;
      if (due_rsp.size() == 0) begin
        $error("response with none due: %p", a);
        errors++;
        return;
      end
      e = due_rsp.pop_front();
      field_mismatch("read_data", e.read_data, a.read_data);
      field_mismatch("access_ok", e.access_ok, a.access_ok);
      field_mismatch("vblank_request", e.vblank_request, a.vblank_request);
      field_mismatch("stat_request", e.stat_request, a.stat_request);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   ready_hold;
  int unsigned cycle_count;

  lmts_req_if req_ch ();
  lmts_rsp_if rsp_ch ();

  lcd_timing_board board = new();

  lcd_mode_timing_stat_top #(
    .VISIBLE_LINES(VISIBLE_LINES),
    .LAST_LINE    (LAST_LINE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Response side: ready drops in random bursts except near the end of the run.
  always @(posedge clk) begin
    if (ready_hold != 0 && !calm) begin
      ready_hold    <= ready_hold - 1;
      rsp_ch.ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold    <= $urandom_range(0, 13);
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= 1'b1;
    end
  end

  // Every accepted response is checked.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.payload);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lcd_mode_timing_stat_top] ERROR");
      $finish;
    end
  end

  function automatic lmts_req_t make_req(logic [1:0] op, logic [6:0] cyc, logic [15:0] addr,
                                         logic [7:0] data);
    lmts_req_t r;
    r.op          = op;
    r.tick_cycles = cyc;
    r.bus_address = addr;
    r.write_data  = data;
    return r;
  endfunction

  // Mostly long ticks so that frames complete, with reads and writes mixed in and
  // rare display-off, LY reset and undecoded requests.
  function automatic lmts_req_t random_req();
    lmts_req_t   r;
    int unsigned pick;
    int unsigned sub;
    r    = make_req(OP_TICK, 7'($urandom), 16'($urandom), 8'($urandom));
    pick = $urandom_range(0, 999);
    sub  = $urandom_range(0, 9);
    if (pick < 2) begin
      r.op          = OP_WRITE;
      r.bus_address = ADDR_LCDC;
      r.write_data[LCDC_DISPLAY_BIT] = 1'b0;
    end else if (pick < 4) begin
      r.op          = OP_WRITE;
      r.bus_address = ADDR_LY;
    end else if (pick < 5) begin
      r.op = OP_UNUSED;
    end else if (pick < 650) begin
      if (sub < 4) r.tick_cycles = 7'd64;
      else if (sub < 7) r.tick_cycles = 7'($urandom_range(65, 127));
      else r.tick_cycles = 7'($urandom_range(0, 64));
    end else if (pick < 800) begin
      r.op = OP_READ;
      case (sub)
        0, 1, 2: r.bus_address = ADDR_STAT;
        3, 4:    r.bus_address = ADDR_LY;
        5, 6:    r.bus_address = ADDR_LYC;
        7:       r.bus_address = ADDR_LCDC;
        8:       r.bus_address = 16'hFF42 + 16'($urandom_range(0, 1));
        default: ;
      endcase
    end else begin
      r.op = OP_WRITE;
      case (sub)
        0, 1: r.bus_address = ADDR_STAT;
        2, 3: begin
          r.bus_address = ADDR_LYC;
          if ($urandom_range(0, 4) != 0) r.write_data = 8'($urandom_range(0, LAST_LINE));
        end
        4: begin
          r.bus_address = ADDR_LCDC;
          r.write_data[LCDC_DISPLAY_BIT] = 1'b1;
        end
        5: r.bus_address = 16'($urandom_range(16'h8000, 16'h9FFF));
        6: r.bus_address = 16'($urandom_range(16'hFF68, 16'hFF6B));
        7: begin
          case ($urandom_range(0, 4))
            0:       r.bus_address = 16'h7FFF;
            1:       r.bus_address = 16'hA000;
            2:       r.bus_address = 16'hFF67;
            3:       r.bus_address = 16'hFF6C;
            default: r.bus_address = 16'hFF42;
          endcase
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Presents one request, waits for it to be taken, then maybe idles a while.
  task automatic push_request(lmts_req_t r);
    req_ch.payload <= r;
    req_ch.valid   <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Holds off new requests until every response due has come back.
  task automatic drain_responses();
    if (board.pending() != 0) begin
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned sent;
    rst            = 1'b1;
    calm           = 1'b0;
    ready_hold     = 0;
    cycle_count    = 0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, display off, full enables, a whole frame of large ticks,
    // empty ticks, LY reset, tile and palette windows, invalid accesses and the
    // undecoded op.
    push_request(make_req(OP_READ, 7'd0, ADDR_STAT, 8'h00));
    push_request(make_req(OP_TICK, 7'd64, 16'h0000, 8'h00));
    push_request(make_req(OP_READ, 7'd0, ADDR_LY, 8'h00));
    push_request(make_req(OP_WRITE, 7'd0, ADDR_LCDC, 8'hFF));
    push_request(make_req(OP_WRITE, 7'd0, ADDR_STAT, 8'hFF));
    push_request(make_req(OP_WRITE, 7'd0, ADDR_LYC, 8'h01));
    repeat (FRAME_TICKS) push_request(make_req(OP_TICK, 7'd127, 16'hFFFF, 8'hFF));
    push_request(make_req(OP_READ, 7'd0, ADDR_STAT, 8'h00));
    push_request(make_req(OP_READ, 7'd0, ADDR_LYC, 8'h00));
    push_request(make_req(OP_TICK, 7'd0, 16'h0000, 8'h00));
    push_request(make_req(OP_WRITE, 7'd0, ADDR_LY, 8'hA5));
    push_request(make_req(OP_READ, 7'd0, ADDR_LY, 8'h00));
    push_request(make_req(OP_WRITE, 7'd0, 16'h8000, 8'h5A));
    push_request(make_req(OP_WRITE, 7'd0, 16'h9FFF, 8'hA5));
    push_request(make_req(OP_WRITE, 7'd0, 16'hFF68, 8'h00));
    push_request(make_req(OP_WRITE, 7'd0, 16'hFF6B, 8'hFF));
    push_request(make_req(OP_WRITE, 7'd0, 16'hA000, 8'hFF));
    push_request(make_req(OP_READ, 7'd0, ADDR_LCDC, 8'h00));
    push_request(make_req(OP_UNUSED, 7'h7F, 16'hFFFF, 8'hFF));
    push_request(make_req(OP_WRITE, 7'd0, ADDR_LCDC, 8'h7F));
    push_request(make_req(OP_TICK, 7'd64, 16'h0000, 8'h00));
    push_request(make_req(OP_READ, 7'd0, ADDR_STAT, 8'h00));
    drain_responses();

    // Random part with the display switched back on.
    push_request(make_req(OP_WRITE, 7'd0, ADDR_LCDC, 8'h80));
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      push_request(random_req());
      sent++;
      if (sent % 300 == 0) drain_responses();
    end

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    repeat (TAIL_ITEMS) push_request(random_req());
    drain_responses();
    repeat (4) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[lcd_mode_timing_stat_top] OK");
    end else begin
      $display("[lcd_mode_timing_stat_top] ERROR");
    end
    $finish;
  end

endmodule
